@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_CLKD(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ hdl/rqt_pkg.sv @@
// Types, constants and datapath step functions of the matrix-to-quaternion block.
package rqt_pkg;

    localparam int FRAC_BITS = 14;
    localparam int SQ_SHIFT  = FRAC_BITS - 2;
    localparam int SQ_STEPS  = 15;
    localparam int DIV_STEPS = 16;
    localparam int N_STAGES  = SQ_STEPS + 1 + DIV_STEPS + 1;
    localparam int N_LANES   = 3;

    localparam logic signed [15:0] ONE_Q   = 16'sd16384;
    localparam logic signed [15:0] SAT_POS = 16'sh7FFF;
    localparam logic signed [15:0] SAT_NEG = 16'sh8000;

    localparam logic [1:0] PIV_W = 2'd0;
    localparam logic [1:0] PIV_X = 2'd1;
    localparam logic [1:0] PIV_Y = 2'd2;
    localparam logic [1:0] PIV_Z = 2'd3;

    typedef struct packed {
        logic signed [15:0] row0_col0;
        logic signed [15:0] row0_col1;
        logic signed [15:0] row0_col2;
        logic signed [15:0] row1_col0;
        logic signed [15:0] row1_col1;
        logic signed [15:0] row1_col2;
        logic signed [15:0] row2_col0;
        logic signed [15:0] row2_col1;
        logic signed [15:0] row2_col2;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic [1:0]         pivot_index;
    } out_item_t;

    // Classified item handed from the front end to the back end.
    typedef struct packed {
        logic [16:0]                 arg;
        logic                        zero;
        logic [1:0]                  idx;
        logic [N_LANES-1:0][16:0]    mag;
        logic [N_LANES-1:0]          neg;
    } job_t;

    // One stage of the square root and divider pipeline.
    typedef struct packed {
        logic [29:0]                 n;
        logic [17:0]                 rem;
        logic [14:0]                 root;
        logic [16:0]                 dvs;
        logic [N_LANES-1:0][16:0]    mag;
        logic [N_LANES-1:0][15:0]    lo;
        logic [N_LANES-1:0][17:0]    r;
        logic [N_LANES-1:0][15:0]    q;
        logic [N_LANES-1:0]          ovf;
        logic [N_LANES-1:0]          neg;
        logic [1:0]                  idx;
        logic                        zero;
    } stage_t;

    // Stage k: square root digit, divider setup, or one quotient bit per lane.
    function automatic stage_t stage_fn(stage_t s, int k);
        stage_t      o;
        logic [17:0] sh;
        logic [17:0] trial;
        logic [17:0] dsh;
        logic [16:0] dnew;
        o = s;
        if (k < SQ_STEPS) begin
            sh    = {s.rem[15:0], s.n[29:28]};
            trial = {1'b0, s.root, 2'b01};
            o.n   = {s.n[27:0], 2'b00};
            if (sh >= trial) begin
                o.rem  = sh - trial;
                o.root = {s.root[13:0], 1'b1};
            end else begin
                o.rem  = sh;
                o.root = {s.root[13:0], 1'b0};
            end
        end else if (k == SQ_STEPS) begin
            dnew  = {s.root, 2'b00};
            o.dvs = dnew;
            for (int i = 0; i < N_LANES; i++) begin
                o.ovf[i] = ({2'b00, s.mag[i][16:2]} >= dnew);
                o.r[i]   = {3'b000, s.mag[i][16:2]};
                o.lo[i]  = {s.mag[i][1:0], 14'd0};
                o.q[i]   = '0;
            end
        end else begin
            for (int i = 0; i < N_LANES; i++) begin
                dsh      = {s.r[i][16:0], s.lo[i][15]};
                o.lo[i]  = {s.lo[i][14:0], 1'b0};
                if (dsh >= {1'b0, s.dvs}) begin
                    o.r[i] = dsh - {1'b0, s.dvs};
                    o.q[i] = {s.q[i][14:0], 1'b1};
                end else begin
                    o.r[i] = dsh;
                    o.q[i] = {s.q[i][14:0], 1'b0};
                end
            end
        end
        return o;
    endfunction

    // Applies the sign to a quotient magnitude and saturates to 16 bits.
    function automatic logic signed [15:0] sat_fn(logic [15:0] q, logic ovf, logic neg);
        logic signed [15:0] v;
        if (!neg) begin
            v = (ovf || q[15]) ? SAT_POS : signed'(q);
        end else begin
            v = (ovf || (q > 16'd32768)) ? SAT_NEG : signed'(16'd0 - q);
        end
        return v;
    endfunction

endpackage

@@ hdl/rqt_front.sv @@
// Front end: forms the trace combinations, picks the pivot and the off-diagonal terms.
module rqt_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rqt_pkg::in_item_t s_payload,
    output logic              job_valid,
    input  logic              job_ready,
    output rqt_pkg::job_t     job
);
    import rqt_pkg::*;

    logic               fv_reg;
    job_t               job_reg;
    job_t               job_next;
    logic signed [17:0] e11, e22, e33;
    logic signed [17:0] t0, t1, t2, t3, best;
    logic signed [18:0] argw;
    logic [1:0]         idx;
    logic signed [16:0] d23, s23, d31, s31, d12, s12;
    logic signed [16:0] sv [N_LANES];

    assign s_ready   = !fv_reg || job_ready;
    assign job_valid = fv_reg;
    assign job       = job_reg;

    assign e11 = 18'(s_payload.row0_col0);
    assign e22 = 18'(s_payload.row1_col1);
    assign e33 = 18'(s_payload.row2_col2);
    assign t0  = e11 + e22 + e33;
    assign t1  = e11 - e22 - e33;
    assign t2  = e22 - e11 - e33;
    assign t3  = e33 - e11 - e22;

    assign d23 = 17'(s_payload.row1_col2) - 17'(s_payload.row2_col1);
    assign s23 = 17'(s_payload.row1_col2) + 17'(s_payload.row2_col1);
    assign d31 = 17'(s_payload.row2_col0) - 17'(s_payload.row0_col2);
    assign s31 = 17'(s_payload.row2_col0) + 17'(s_payload.row0_col2);
    assign d12 = 17'(s_payload.row0_col1) - 17'(s_payload.row1_col0);
    assign s12 = 17'(s_payload.row0_col1) + 17'(s_payload.row1_col0);

    // Ties keep the earlier component.
    always_comb begin
        best = t0;
        idx  = PIV_W;
        if (t1 > best) begin
            best = t1;
            idx  = PIV_X;
        end
        if (t2 > best) begin
            best = t2;
            idx  = PIV_Y;
        end
        if (t3 > best) begin
            best = t3;
            idx  = PIV_Z;
        end
    end

    assign argw = 19'(best) + 19'(ONE_Q);

    always_comb begin
        unique case (idx)
            PIV_W: begin
                sv[0] = d23; sv[1] = d31; sv[2] = d12;
            end
            PIV_X: begin
                sv[0] = d23; sv[1] = s12; sv[2] = s31;
            end
            PIV_Y: begin
                sv[0] = d31; sv[1] = s12; sv[2] = s23;
            end
            PIV_Z: begin
                sv[0] = d12; sv[1] = s31; sv[2] = s23;
            end
            default: begin
                sv[0] = d23; sv[1] = d31; sv[2] = d12;
            end
        endcase
    end

    always_comb begin
        job_next.arg  = argw[18] ? 17'd0 : argw[16:0];
        job_next.zero = argw[18] || (argw == 19'sd0);
        job_next.idx  = idx;
        for (int i = 0; i < N_LANES; i++) begin
            job_next.neg[i] = sv[i][16];
            job_next.mag[i] = sv[i][16] ? 17'(-sv[i]) : 17'(sv[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= 1'b0;
        end else if (s_ready) begin
            fv_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            job_reg <= job_next;
        end
    end

endmodule

@@ hdl/rqt_queue.sv @@
// Two-entry queue that decouples the front end from the back end.
module rqt_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  rqt_pkg::job_t in_job,
    output logic          out_valid,
    input  logic          out_ready,
    output rqt_pkg::job_t out_job
);
    import rqt_pkg::*;

    job_t       ent_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_job   = ent_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= in_job;
        end
    end

endmodule

@@ hdl/rqt_back.sv @@
// Back end: pipelined square root, three pipelined dividers and the output register.
module rqt_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               job_valid,
    output logic               job_ready,
    input  rqt_pkg::job_t      job,
    output logic               m_valid,
    input  logic               m_ready,
    output rqt_pkg::out_item_t m_payload
);
    import rqt_pkg::*;

    logic [N_STAGES-1:0] sv_reg;
    stage_t              st_reg [N_STAGES];
    stage_t              st_init;
    logic                mv_reg;
    out_item_t           out_reg, out_next;
    logic                en;
    logic signed [15:0]  v [N_LANES];
    logic signed [15:0]  pv;
    stage_t              fin;

    assign en        = !mv_reg || m_ready;
    assign job_ready = en;
    assign m_valid   = mv_reg;
    assign m_payload = out_reg;

    always_comb begin
        st_init      = '0;
        st_init.n    = {1'b0, job.arg, SQ_SHIFT'(0)};
        st_init.mag  = job.mag;
        st_init.neg  = job.neg;
        st_init.idx  = job.idx;
        st_init.zero = job.zero;
    end

    assign fin = st_reg[N_STAGES-1];
    assign pv  = signed'({1'b0, fin.root});

    always_comb begin
        for (int i = 0; i < N_LANES; i++) begin
            v[i] = sat_fn(fin.q[i], fin.ovf[i], fin.neg[i]);
        end
        unique case (fin.idx)
            PIV_W: begin
                out_next.quat_w = pv;   out_next.quat_x = v[0];
                out_next.quat_y = v[1]; out_next.quat_z = v[2];
            end
            PIV_X: begin
                out_next.quat_w = v[0]; out_next.quat_x = pv;
                out_next.quat_y = v[1]; out_next.quat_z = v[2];
            end
            PIV_Y: begin
                out_next.quat_w = v[0]; out_next.quat_x = v[1];
                out_next.quat_y = pv;   out_next.quat_z = v[2];
            end
            PIV_Z: begin
                out_next.quat_w = v[0]; out_next.quat_x = v[1];
                out_next.quat_y = v[2]; out_next.quat_z = pv;
            end
            default: begin
                out_next.quat_w = pv;   out_next.quat_x = v[0];
                out_next.quat_y = v[1]; out_next.quat_z = v[2];
            end
        endcase
        out_next.pivot_index = fin.idx;
        if (fin.zero) begin
            out_next.quat_w      = ONE_Q;
            out_next.quat_x      = '0;
            out_next.quat_y      = '0;
            out_next.quat_z      = '0;
            out_next.pivot_index = PIV_W;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sv_reg <= '0;
            mv_reg <= 1'b0;
        end else if (en) begin
            sv_reg <= {sv_reg[N_STAGES-2:0], job_valid};
            mv_reg <= sv_reg[N_STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0] <= st_init;
            out_reg   <= out_next;
        end
    end

    for (genvar k = 1; k < N_STAGES; k++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[k] <= stage_fn(st_reg[k-1], k - 1);
            end
        end
    end

endmodule

@@ hdl/rotation_matrix_to_quaternion_core.sv @@
// An accepted matrix passes the front register, the queue, the back stages and the output register.
// Throughput: one transaction per cycle unless m_ready stalls; the 33 back stages advance together.
// A stall on the result side holds the back pipeline; a two-entry queue absorbs the front.
// Reset: aresetn is synchronous, active low, and clears all valid and pointer state.
// Payload registers carry no reset.
module rotation_matrix_to_quaternion_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rqt_pkg::in_item_t  s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output rqt_pkg::out_item_t m_payload
);
    import rqt_pkg::*;

    // Front-end results: trace combinations, pivot choice, and the three
    // off-diagonal terms split into sign and magnitude.
    logic f_valid, f_ready;
    job_t f_job;

    // Queue output feeding the square root and divider pipeline.
    logic q_valid, q_ready;
    job_t q_job;

    // The front end registers one classified transaction and hands it to
    // the queue whenever there is room.
    rqt_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .job_valid (f_valid),
        .job_ready (f_ready),
        .job       (f_job)
    );

    // The queue lets the front end keep accepting while the back end
    // is held by a stalled output.
    rqt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_job    (f_job),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_job   (q_job)
    );

    // The back end takes the square root of the pivot argument one digit per
    // stage, then divides each scaled off-diagonal term by four times the
    // root one quotient bit per stage, and saturates into the output register.
    rqt_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (q_valid),
        .job_ready (q_ready),
        .job       (q_job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

@@ hdl/rqt_checker.sv @@
// Port-level checker for the matrix-to-quaternion core, with its bind.
`include "assert_macros.svh"

module rqt_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input rqt_pkg::in_item_t  s_payload,
    input logic               m_valid,
    input logic               m_ready,
    input rqt_pkg::out_item_t m_payload
);
    import rqt_pkg::*;

    // A stalled result must hold.
    `ASSERT_CLKD(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_payload), "result changed while stalled")

    // Reset empties the result side.
    `ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_valid, "result valid after reset")

    // The chosen component is always strictly positive.
    `ASSERT_CLKD(a_pivot_pos, m_valid |-> ((m_payload.pivot_index == PIV_W && m_payload.quat_w > 16'sd0) || (m_payload.pivot_index == PIV_X && m_payload.quat_x > 16'sd0) || (m_payload.pivot_index == PIV_Y && m_payload.quat_y > 16'sd0) || (m_payload.pivot_index == PIV_Z && m_payload.quat_z > 16'sd0)), "pivot component not positive")

endmodule

bind rotation_matrix_to_quaternion_core rqt_checker u_rqt_checker (.*);

@@ tb/rotation_matrix_to_quaternion_core_tb.sv @@
// Self-checking testbench for the rotation-matrix-to-quaternion core.
module rotation_matrix_to_quaternion_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rqt_pkg::*;

    localparam int LATENCY = 35;
    localparam int WATCHDOG_LIMIT = 20000;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_payload;

    // Idle percentages for the sender and the receiver, changed per phase.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit failed = 1'b0;
    int idle_cycles = 0;

    out_item_t quat_queue[$];

    always #5 aclk = ~aclk;

    rotation_matrix_to_quaternion_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload)
    );

    // Integer square root, floor.
    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > n) bit_v >>= 2;
        while (bit_v != 0) begin
            if (n >= res + bit_v) begin
                n -= res + bit_v;
                res = (res >> 1) + bit_v;
            end else begin
                res >>= 1;
            end
            bit_v >>= 2;
        end
        return res;
    endfunction

    // Off-diagonal term scaled by one quarter over the pivot, truncated toward zero.
    function automatic longint quarter_div(longint s, longint unsigned piv);
        longint unsigned mag;
        longint q;
        mag = (s < 0) ? -s : s;
        q = longint'((mag << FRAC_BITS) / (piv * 4));
        return (s < 0) ? -q : q;
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767) return SAT_POS;
        if (v < -32768) return SAT_NEG;
        return v[15:0];
    endfunction

    // Shepperd's method: pick the largest trace combination as the pivot.
    function automatic out_item_t predict_quat(in_item_t m);
        longint a11, a12, a13, a21, a22, a23, a31, a32, a33;
        longint t[4];
        longint q[4];
        longint best, arg;
        longint unsigned piv;
        logic [1:0] idx;
        out_item_t r;
        a11 = m.row0_col0; a12 = m.row0_col1; a13 = m.row0_col2;
        a21 = m.row1_col0; a22 = m.row1_col1; a23 = m.row1_col2;
        a31 = m.row2_col0; a32 = m.row2_col1; a33 = m.row2_col2;
        t[0] = a11 + a22 + a33;
        t[1] = a11 - a22 - a33;
        t[2] = -a11 + a22 - a33;
        t[3] = -a11 - a22 + a33;
        best = t[0];
        idx = PIV_W;
        for (int k = 1; k < 4; k++) begin
            if (t[k] > best) begin
                best = t[k];
                idx = k[1:0];
            end
        end
        arg = best + (longint'(1) << FRAC_BITS);
        if (arg < 0) arg = 0;
        piv = int_sqrt(longint'(arg) << (FRAC_BITS - 2));
        if (piv == 0) begin
            r.quat_w = ONE_Q;
            r.quat_x = '0;
            r.quat_y = '0;
            r.quat_z = '0;
            r.pivot_index = PIV_W;
            return r;
        end
        case (idx)
            PIV_W: begin
                q[1] = quarter_div(a23 - a32, piv);
                q[2] = quarter_div(a31 - a13, piv);
                q[3] = quarter_div(a12 - a21, piv);
            end
            PIV_X: begin
                q[0] = quarter_div(a23 - a32, piv);
                q[2] = quarter_div(a12 + a21, piv);
                q[3] = quarter_div(a31 + a13, piv);
            end
            PIV_Y: begin
                q[0] = quarter_div(a31 - a13, piv);
                q[1] = quarter_div(a12 + a21, piv);
                q[3] = quarter_div(a23 + a32, piv);
            end
            default: begin
                q[0] = quarter_div(a12 - a21, piv);
                q[1] = quarter_div(a31 + a13, piv);
                q[2] = quarter_div(a23 + a32, piv);
            end
        endcase
        q[idx] = longint'(piv);
        r.quat_w = clamp16(q[0]);
        r.quat_x = clamp16(q[1]);
        r.quat_y = clamp16(q[2]);
        r.quat_z = clamp16(q[3]);
        r.pivot_index = idx;
        return r;
    endfunction

    // Sends one matrix; valid stays high across back-to-back transactions.
    task automatic send_matrix(in_item_t m);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= m;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        quat_queue.push_back(predict_quat(m));
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (quat_queue.size() != 0) @(negedge aclk);
        repeat (LATENCY + 5) @(negedge aclk);
    endtask

    function automatic in_item_t diag_matrix(logic signed [15:0] d0, logic signed [15:0] d1,
                                             logic signed [15:0] d2);
        in_item_t m;
        m = '0;
        m.row0_col0 = d0;
        m.row1_col1 = d1;
        m.row2_col2 = d2;
        return m;
    endfunction

    // Directed: identity, each pivot, ties, negative diagonals and extremes.
    task automatic test_directed();
        in_item_t m;
        send_matrix(diag_matrix(ONE_Q, ONE_Q, ONE_Q));
        send_matrix(diag_matrix(ONE_Q, -ONE_Q, -ONE_Q));
        send_matrix(diag_matrix(-ONE_Q, ONE_Q, -ONE_Q));
        send_matrix(diag_matrix(-ONE_Q, -ONE_Q, ONE_Q));
        // All four combinations equal: the tie goes to w.
        send_matrix(diag_matrix(16'sd0, 16'sd0, 16'sd0));
        // The x and y combinations tie above w and z.
        send_matrix(diag_matrix(16'sd0, 16'sd0, -ONE_Q));
        // All-negative diagonals: the largest combination still lands at or above zero.
        send_matrix(diag_matrix(SAT_NEG, SAT_NEG, SAT_NEG));
        send_matrix(diag_matrix(-16'sd16384, -16'sd16384, -16'sd16384));
        m = '1;
        send_matrix(m);
        m = {9{SAT_POS}};
        send_matrix(m);
        m = {9{SAT_NEG}};
        send_matrix(m);
        // The smallest pivot with extreme off-diagonal terms drives the lanes
        // to the ends of their range.
        m = {SAT_NEG, SAT_POS, SAT_NEG, SAT_NEG, SAT_NEG, SAT_POS, SAT_POS, SAT_NEG,
             SAT_NEG};
        m.row0_col0 = 16'sd0; m.row1_col1 = 16'sd0; m.row2_col2 = 16'sd0;
        send_matrix(m);
        m.row0_col1 = SAT_NEG; m.row1_col0 = SAT_POS;
        send_matrix(m);
        for (int i = 0; i < 9; i++) begin
            m = diag_matrix(16'sd0, 16'sd0, 16'sd0);
            m[i*16 +: 16] = SAT_POS;
            send_matrix(m);
            m[i*16 +: 16] = SAT_NEG;
            send_matrix(m);
        end
    endtask

    function automatic int i_diag(int k);
        return (8 - 4 * k) * 16;
    endfunction

    // Random: mostly entries within [-16384, 16384], some with one large diagonal entry, the rest raw bit patterns.
    task automatic test_random(int count);
        in_item_t m;
        for (int n = 0; n < count; n++) begin
            m = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
            if ($urandom_range(99) < 70) begin
                for (int i = 0; i < 9; i++)
                    m[i*16 +: 16] = $signed(16'($urandom_range(32768))) - 16'sd16384;
                if ($urandom_range(3) == 0)
                    m[i_diag($urandom_range(2)) +: 16] = 16'($urandom_range(16384, 32767));
            end
            send_matrix(m);
        end
    endtask

    // Receiver: random stalls and the result check.
    always @(negedge aclk) begin
        m_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    always @(posedge aclk) begin
        out_item_t exp_q;
        if (aresetn && m_valid && m_ready) begin
            if (quat_queue.size() == 0) begin
                $display("%0t: unexpected quaternion transaction %h", $realtime, m_payload);
                failed = 1'b1;
            end else begin
                exp_q = quat_queue.pop_front();
                if (exp_q.quat_w !== m_payload.quat_w ||
                    exp_q.quat_x !== m_payload.quat_x ||
                    exp_q.quat_y !== m_payload.quat_y ||
                    exp_q.quat_z !== m_payload.quat_z ||
                    exp_q.pivot_index !== m_payload.pivot_index) begin
                    $display("%0t: expected w,x,y,z,piv %h, got %h",
                             $realtime, exp_q, m_payload);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog: counts cycles in which no transaction moves on either side.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        // Hold off until the pipeline is empty before changing pressure.
        drain_results();
        test_random(150);
        send_idle_pct = 57;
        test_random(150);
        send_idle_pct = 0;
        recv_stall_pct = 57;
        test_random(150);
        send_idle_pct = 6;
        recv_stall_pct = 6;
        test_random(150);
        drain_results();
        if (!failed) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
